// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/rrc_pkg.sv
// Types and constants for the rectangle raster canvas.
// No dependencies.
package rrc_pkg;

   localparam int BOUND_W = 28;
   localparam int CSR_DATA_W = 9;
   localparam logic [7:0] BG_RESET = 8'd32;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_DRAW  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } rrc_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_LATCHED  = 2'd2,
      STATUS_OUTSIDE  = 2'd3
   } rrc_status_type;

   typedef enum logic [1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1,
      CSR_BACKGROUND    = 2'd2
   } rrc_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SWEEP,
      ST_FETCH,
      ST_RESP
   } rrc_state_type;

   typedef struct packed {
      logic signed [BOUND_W-1:0] x_lo;
      logic signed [BOUND_W-1:0] x_hi;
      logic signed [BOUND_W-1:0] x_lo1;
      logic signed [BOUND_W-1:0] x_hi1;
      logic signed [BOUND_W-1:0] y_lo;
      logic signed [BOUND_W-1:0] y_hi;
      logic signed [BOUND_W-1:0] y_lo1;
      logic signed [BOUND_W-1:0] y_hi1;
   } rrc_bounds_type;

   typedef struct packed {
      logic in_rect;
      logic border;
   } rrc_hit_type;

endpackage

// File: rtl/rrc_canvas_mem.sv
// Canvas byte store: one write port, one registered read port.
// No dependencies.
module rrc_canvas_mem #(
   parameter int AW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [0:(1 << AW)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rrc_pixel_test.sv
// Per-pixel inside/border classifier against registered rectangle bounds.
// Uses rrc_pkg.
module rrc_pixel_test #(
   parameter int IW = 8,
   parameter int FRACTION_BITS = 8
) (
   input  logic [IW-1:0]           col,
   input  logic [IW-1:0]           row,
   input  rrc_pkg::rrc_bounds_type bounds,
   output rrc_pkg::rrc_hit_type    hit
);

   localparam int BW = rrc_pkg::BOUND_W;

   logic signed [BW-1:0] px;
   logic signed [BW-1:0] py;
   logic                 in_rect;

   assign px = $signed(BW'(col) << FRACTION_BITS);
   assign py = $signed(BW'(row) << FRACTION_BITS);

   assign in_rect = (px >= bounds.x_lo) && (px <= bounds.x_hi) &&
                    (py >= bounds.y_lo) && (py <= bounds.y_hi);

   assign hit.in_rect = in_rect;
   assign hit.border  = in_rect &&
                        ((px < bounds.x_lo1) || (px > bounds.x_hi1) ||
                         (py < bounds.y_lo1) || (py > bounds.y_hi1));

endmodule

// File: rtl/rectangle_raster_canvas_top.sv
// Rectangle raster canvas top level: sequencer, config registers, canvas store.
// Uses rrc_pkg, rrc_pixel_test, rrc_canvas_mem and assert_macros.svh.
//
// One item at a time; busy stays high from the accept until the result strobe.
// A clear sweeps the canvas; a draw registers its bounds, then sweeps (w, h the
// canvas size clamped to MAX_SIDE): the sweep visits one pixel per cycle through
// the single write port of the canvas store. A read waits on the registered store
// read. A rejected or refused draw, a read outside the canvas, an empty canvas and
// an unknown kind go straight to the response. rsp_strobe is high for exactly one
// cycle per item and cannot be held off. The store has no clearing pass; pixels
// read before any clear or draw wrote them return undefined data.
`include "assert_macros.svh"

module rectangle_raster_canvas_top #(
   parameter int MAX_SIDE = 256,
   parameter int FRACTION_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic                               req_filled,
   input  logic signed [23:0]                 req_rect_left,
   input  logic signed [23:0]                 req_rect_top,
   input  logic signed [23:0]                 req_rect_span_x,
   input  logic signed [23:0]                 req_rect_span_y,
   input  logic [7:0]                         req_paint_byte,
   input  logic [7:0]                         req_read_column,
   input  logic [7:0]                         req_read_row,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [7:0]                         rsp_pixel_value,
   input  logic                               csr_write_enable,
   input  logic [1:0]                         csr_index,
   input  logic [rrc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int CMP_W = (SW > 9) ? SW : 9;
   localparam int AW = 2 * IW;
   localparam int BW = rrc_pkg::BOUND_W;
   localparam logic signed [BW-1:0] ONE = BW'(1) << FRACTION_BITS;

   rrc_pkg::rrc_state_type  state_ff, state_in;
   logic [8:0]              width_ff, width_in;
   logic [8:0]              height_ff, height_in;
   logic [7:0]              bg_ff, bg_in;
   logic                    err_ff, err_in;
   logic                    clear_ff, clear_in;
   logic                    fill_ff, fill_in;
   logic [7:0]              paint_ff, paint_in;
   logic [1:0]              status_ff, status_in;
   logic                    read_ok_ff, read_ok_in;
   logic [IW-1:0]           col_ff, col_in;
   logic [IW-1:0]           row_ff, row_in;
   logic signed [BW-1:0]    left_ff, left_in;
   logic signed [BW-1:0]    top_ff, top_in;
   logic signed [BW-1:0]    spx_ff, spx_in;
   logic signed [BW-1:0]    spy_ff, spy_in;
   logic signed [BW-1:0]    spx1_ff, spx1_in;
   logic signed [BW-1:0]    spy1_ff, spy1_in;
   rrc_pkg::rrc_bounds_type bounds_ff, bounds_in;

   logic [SW-1:0]           used_w;
   logic [SW-1:0]           used_h;
   logic                    accept;
   logic                    canvas_empty;
   logic                    shape_bad;
   logic                    read_out;
   logic                    last_col;
   logic                    last_row;
   rrc_pkg::rrc_hit_type    hit;
   logic                    mem_we;
   logic                    mem_re;
   logic [AW-1:0]           mem_addr;
   logic [7:0]              mem_rdata;

   assign used_w = (CMP_W'(width_ff) > CMP_W'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(width_ff);
   assign used_h = (CMP_W'(height_ff) > CMP_W'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(height_ff);

   assign accept       = start && !busy;
   assign canvas_empty = (used_w == '0) || (used_h == '0);
   assign shape_bad    = (req_rect_span_x <= 24'sd0) || (req_rect_span_y <= 24'sd0);
   assign read_out     = (CMP_W'(req_read_column) >= CMP_W'(used_w)) ||
                         (CMP_W'(req_read_row) >= CMP_W'(used_h));
   assign last_col     = (SW'(col_ff) == SW'(used_w - SW'(1)));
   assign last_row     = (SW'(row_ff) == SW'(used_h - SW'(1)));
   assign mem_addr     = {row_ff, col_ff};

   rrc_pixel_test #(
      .IW            (IW),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_pixel_test (
      .col    (col_ff),
      .row    (row_ff),
      .bounds (bounds_ff),
      .hit    (hit)
   );

   rrc_canvas_mem #(
      .AW (AW)
   ) u_canvas_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (paint_ff),
      .rd_en   (mem_re),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  rrc_pkg::KIND_CLEAR: begin
                     state_in = canvas_empty ? rrc_pkg::ST_RESP : rrc_pkg::ST_SWEEP;
                  end
                  rrc_pkg::KIND_DRAW: begin
                     state_in = (err_ff || shape_bad || canvas_empty) ?
                                rrc_pkg::ST_RESP : rrc_pkg::ST_SETUP;
                  end
                  rrc_pkg::KIND_READ: begin
                     state_in = read_out ? rrc_pkg::ST_RESP : rrc_pkg::ST_FETCH;
                  end
                  default: begin
                     state_in = rrc_pkg::ST_RESP;
                  end
               endcase
            end
         end
         rrc_pkg::ST_SETUP: begin
            state_in = rrc_pkg::ST_SWEEP;
         end
         rrc_pkg::ST_SWEEP: begin
            if (last_col && last_row) begin
               state_in = rrc_pkg::ST_RESP;
            end
         end
         rrc_pkg::ST_FETCH: begin
            state_in = rrc_pkg::ST_RESP;
         end
         rrc_pkg::ST_RESP: begin
            state_in = rrc_pkg::ST_IDLE;
         end
         default: begin
            state_in = rrc_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      case (state_ff)
         rrc_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         rrc_pkg::ST_SWEEP: begin
            mem_we = clear_ff || (fill_ff ? hit.in_rect : hit.border);
         end
         rrc_pkg::ST_FETCH: begin
            mem_re = 1'b1;
         end
         rrc_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      bg_in      = bg_ff;
      err_in     = err_ff;
      clear_in   = clear_ff;
      fill_in    = fill_ff;
      paint_in   = paint_ff;
      status_in  = status_ff;
      read_ok_in = read_ok_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      left_in    = left_ff;
      top_in     = top_ff;
      spx_in     = spx_ff;
      spy_in     = spy_ff;
      spx1_in    = spx1_ff;
      spy1_in    = spy1_ff;
      bounds_in  = bounds_ff;

      if (csr_write_enable) begin
         case (csr_index)
            rrc_pkg::CSR_CANVAS_WIDTH:  width_in  = csr_write_data;
            rrc_pkg::CSR_CANVAS_HEIGHT: height_in = csr_write_data;
            rrc_pkg::CSR_BACKGROUND:    bg_in     = csr_write_data[7:0];
            default: begin
            end
         endcase
      end

      if (accept) begin
         clear_in   = (req_kind == rrc_pkg::KIND_CLEAR);
         fill_in    = req_filled;
         paint_in   = (req_kind == rrc_pkg::KIND_CLEAR) ? bg_ff : req_paint_byte;
         status_in  = rrc_pkg::STATUS_OK;
         read_ok_in = 1'b0;
         col_in     = '0;
         row_in     = '0;
         left_in    = BW'(req_rect_left);
         top_in     = BW'(req_rect_top);
         spx_in     = BW'(req_rect_span_x);
         spy_in     = BW'(req_rect_span_y);
         spx1_in    = BW'(req_rect_span_x) - ONE;
         spy1_in    = BW'(req_rect_span_y) - ONE;
         case (req_kind)
            rrc_pkg::KIND_DRAW: begin
               if (err_ff) begin
                  status_in = rrc_pkg::STATUS_LATCHED;
               end else if (shape_bad) begin
                  status_in = rrc_pkg::STATUS_REJECTED;
                  err_in    = 1'b1;
               end
            end
            rrc_pkg::KIND_READ: begin
               if (read_out) begin
                  status_in = rrc_pkg::STATUS_OUTSIDE;
               end else begin
                  read_ok_in = 1'b1;
                  col_in     = IW'(req_read_column);
                  row_in     = IW'(req_read_row);
               end
            end
            default: begin
            end
         endcase
      end

      if (state_ff == rrc_pkg::ST_SETUP) begin
         bounds_in.x_lo  = left_ff;
         bounds_in.x_hi  = left_ff + spx_ff;
         bounds_in.x_lo1 = left_ff + ONE;
         bounds_in.x_hi1 = left_ff + spx1_ff;
         bounds_in.y_lo  = top_ff;
         bounds_in.y_hi  = top_ff + spy_ff;
         bounds_in.y_lo1 = top_ff + ONE;
         bounds_in.y_hi1 = top_ff + spy1_ff;
      end

      if (state_ff == rrc_pkg::ST_SWEEP) begin
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + IW'(1);
         end else begin
            col_in = col_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rrc_pkg::ST_IDLE;
         width_ff  <= '0;
         height_ff <= '0;
         bg_ff     <= rrc_pkg::BG_RESET;
         err_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bg_ff     <= bg_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      clear_ff   <= clear_in;
      fill_ff    <= fill_in;
      paint_ff   <= paint_in;
      status_ff  <= status_in;
      read_ok_ff <= read_ok_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      left_ff    <= left_in;
      top_ff     <= top_in;
      spx_ff     <= spx_in;
      spy_ff     <= spy_in;
      spx1_ff    <= spx1_in;
      spy1_ff    <= spy1_in;
      bounds_ff  <= bounds_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_pixel_value = (rsp_strobe && read_ok_ff) ? mem_rdata : 8'd0;

   `ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_single_beat, clock, reset, rsp_strobe, !rsp_strobe)
   `ASSERT_IMPL(a_outside_zero, clock, reset,
                rsp_strobe && (rsp_status == rrc_pkg::STATUS_OUTSIDE),
                rsp_pixel_value == 8'd0)

endmodule
